// ===== hdl/luxreg_pkg.sv =====
package luxreg_pkg;

    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] CFG_PWM_PERIOD   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_QUICK_STEP   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_SLOW_STEP    = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_TUNE_TIMEOUT = 2'd3;

    localparam logic [15:0] PWM_PERIOD_RST   = 16'd1000;
    localparam logic [7:0]  QUICK_STEP_RST   = 8'd34;
    localparam logic [7:0]  SLOW_STEP_RST    = 8'd8;
    localparam logic [31:0] TUNE_TIMEOUT_RST = 32'd30000;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_DIM   = 2'd1;
    localparam logic [1:0] ACT_RECAL = 2'd2;

    localparam logic [15:0] RAW_FAULT   = 16'hFFFF;
    localparam logic [16:0] LUX_WINDOW  = 17'd20;
    localparam logic [16:0] QUICK_LIMIT = 17'd200;
    localparam logic [2:0]  GAP_LONG    = 3'd5;
    localparam logic [2:0]  GAP_SHORT   = 3'd2;

    // floor(x/6) = (x * ceil(2^21/6)) >> 21 for x below 2^19
    localparam logic [18:0] DIV6_MULT  = 19'd349526;
    localparam int unsigned DIV6_SHIFT = 21;

    typedef struct packed {
        logic [15:0] raw_reading;
        logic [15:0] target_lux;
        logic [15:0] pwm_width;
        logic        dim_busy;
        logic [31:0] now_ticks;
    } t_in;

    typedef struct packed {
        logic [15:0] current_lux;
        logic [1:0]  action;
        logic [15:0] new_width;
        logic [7:0]  step_size;
        logic [2:0]  dim_gap;
    } t_out;

endpackage

// ===== hdl/lux_regulator_step_core.sv =====
// an item passes the input register and then the result register before o_out_valid rises;
// a stall on the output can hold it in the input register; throughput: one item per cycle
// unless the output stalls; the regulation math sits in one stage between the two registers
// tuning state is read and updated in that same stage, so consecutive items see it in order
// reset (synchronous, active low) empties both stages, clears tuning state and
// loads the configuration registers with their defaults
module lux_regulator_step_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  luxreg_pkg::t_in                     i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output luxreg_pkg::t_out                    o_out_data,
    input  logic                                i_cfg_we,
    input  logic [luxreg_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [luxreg_pkg::CfgDataW-1:0]     i_cfg_wdata
);

    logic [15:0] r_pwm_period;
    logic [7:0]  r_quick_step;
    logic [7:0]  r_slow_step;
    logic [31:0] r_tune_timeout;

    logic              r_s1_valid;
    luxreg_pkg::t_in   r_s1_data;
    logic              r_out_valid;
    luxreg_pkg::t_out  r_out_data;

    logic        r_tuning;
    logic [31:0] r_tune_start;

    logic             out_free;
    logic             s1_adv;
    luxreg_pkg::t_out n_out;
    logic             n_tuning;
    logic [31:0]      n_tune_start;

    assign out_free    = !r_out_valid || i_out_ready;
    assign s1_adv      = r_s1_valid && out_free;
    assign o_in_ready  = !r_s1_valid || out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period   <= luxreg_pkg::PWM_PERIOD_RST;
            r_quick_step   <= luxreg_pkg::QUICK_STEP_RST;
            r_slow_step    <= luxreg_pkg::SLOW_STEP_RST;
            r_tune_timeout <= luxreg_pkg::TUNE_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                luxreg_pkg::CFG_PWM_PERIOD:   r_pwm_period   <= i_cfg_wdata[15:0];
                luxreg_pkg::CFG_QUICK_STEP:   r_quick_step   <= i_cfg_wdata[7:0];
                luxreg_pkg::CFG_SLOW_STEP:    r_slow_step    <= i_cfg_wdata[7:0];
                luxreg_pkg::CFG_TUNE_TIMEOUT: r_tune_timeout <= i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [37:0] prod;
        logic [15:0] lux;
        logic        fault;
        logic        below;
        logic [16:0] dev;
        logic [31:0] start;
        logic [31:0] elapsed;
        logic [7:0]  step;
        logic [16:0] up;

        prod  = 38'({3'd0, r_s1_data.raw_reading} * 19'd5) * 38'(luxreg_pkg::DIV6_MULT);
        fault = (r_s1_data.raw_reading == luxreg_pkg::RAW_FAULT);
        lux   = fault ? luxreg_pkg::RAW_FAULT
                      : prod[luxreg_pkg::DIV6_SHIFT +: 16];
        below = lux < r_s1_data.target_lux;
        dev   = below ? ({1'b0, r_s1_data.target_lux} - {1'b0, lux})
                      : ({1'b0, lux} - {1'b0, r_s1_data.target_lux});
        start   = r_tuning ? r_tune_start : r_s1_data.now_ticks;
        elapsed = r_s1_data.now_ticks - start;
        step    = (dev > luxreg_pkg::QUICK_LIMIT) ? r_quick_step : r_slow_step;
        up      = {1'b0, r_s1_data.pwm_width} + {9'd0, step};

        n_out              = '0;
        n_out.current_lux  = lux;
        n_tuning           = r_tuning;
        n_tune_start       = r_tune_start;

        if (!r_s1_data.dim_busy && !fault) begin
            if (r_s1_data.target_lux == 16'd0) begin
                n_tuning = 1'b0;
                if (r_s1_data.pwm_width != 16'd0) begin
                    n_out.action = luxreg_pkg::ACT_DIM;
                end
            end else if (dev > luxreg_pkg::LUX_WINDOW) begin
                n_tune_start = start;
                if (elapsed > r_tune_timeout) begin
                    n_tuning     = 1'b0;
                    n_out.action = luxreg_pkg::ACT_RECAL;
                end else begin
                    n_tuning        = 1'b1;
                    n_out.step_size = step;
                    n_out.dim_gap   = (step > 8'd1) ? luxreg_pkg::GAP_LONG
                                                    : luxreg_pkg::GAP_SHORT;
                    if (below) begin
                        if (up < {1'b0, r_pwm_period} && step != 8'd0) begin
                            n_out.action    = luxreg_pkg::ACT_DIM;
                            n_out.new_width = up[15:0];
                        end
                    end else if (r_s1_data.pwm_width > {8'd0, step} && step != 8'd0) begin
                        n_out.action    = luxreg_pkg::ACT_DIM;
                        n_out.new_width = r_s1_data.pwm_width - {8'd0, step};
                    end
                end
            end else begin
                n_tuning = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_tuning     <= 1'b0;
            r_tune_start <= '0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_adv) begin
                r_tuning     <= n_tuning;
                r_tune_start <= n_tune_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_data <= i_in_data;
        end
        if (s1_adv) begin
            r_out_data <= n_out;
        end
    end

endmodule

// ===== hdl/luxreg_chk.sv =====
module luxreg_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input luxreg_pkg::t_out o_out_data
);

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result changed while stalled");

    // sensor fault never drives the lamp
    a_fault_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.current_lux == luxreg_pkg::RAW_FAULT |->
            o_out_data.action == luxreg_pkg::ACT_NONE && o_out_data.step_size == 8'd0
            && o_out_data.dim_gap == 3'd0)
        else $error("action on sensor fault");

    a_recal_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.action == luxreg_pkg::ACT_RECAL |->
            o_out_data.step_size == 8'd0 && o_out_data.dim_gap == 3'd0
            && o_out_data.new_width == 16'd0)
        else $error("recalibration carries a step");

    a_gap_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.dim_gap != 3'd0 |->
            (o_out_data.step_size > 8'd1 && o_out_data.dim_gap == luxreg_pkg::GAP_LONG)
            || (o_out_data.step_size <= 8'd1 && o_out_data.dim_gap == luxreg_pkg::GAP_SHORT))
        else $error("dim gap does not match step");

endmodule

bind lux_regulator_step_core luxreg_chk u_luxreg_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== tb/sv/lux_regulator_step_core_tb.sv =====
module lux_regulator_step_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import luxreg_pkg::*;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    t_in                 i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out                o_out_data;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx = '0;
    logic [CfgDataW-1:0] i_cfg_wdata = '0;

    lux_regulator_step_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // regulator copy: settings and tuning state
    logic [15:0] period_r = PWM_PERIOD_RST;
    logic [7:0]  quick_r  = QUICK_STEP_RST;
    logic [7:0]  slow_r   = SLOW_STEP_RST;
    logic [31:0] tmo_r    = TUNE_TIMEOUT_RST;
    logic        tuning   = 1'b0;
    logic [31:0] tune_t0  = '0;

    t_in  meas_queue[$];
    t_out reports_due[$];

    bit calm = 1'b0;
    int mismatches = 0;
    int n_items = 0;
    int n_results = 0;
    int n_dim = 0;
    int n_recal = 0;
    int n_fault = 0;
    int n_busy = 0;
    int n_settings = 1;

    function automatic t_out regulate(input t_in m);
        t_out        r;
        int unsigned lux;
        int unsigned dev;
        int unsigned stp;
        int unsigned up;
        logic [31:0] elapsed;
        bit          below;
        r = '0;
        lux = (m.raw_reading == RAW_FAULT) ? 32'hFFFF : (32'(m.raw_reading) * 5) / 6;
        r.current_lux = 16'(lux);
        if (!m.dim_busy && m.raw_reading != RAW_FAULT) begin
            if (m.target_lux == 16'd0) begin
                tuning = 1'b0;
                if (m.pwm_width != 16'd0) begin
                    r.action = ACT_DIM;
                end
            end else begin
                below = lux < 32'(m.target_lux);
                dev = below ? 32'(m.target_lux) - lux : lux - 32'(m.target_lux);
                if (dev > 32'(LUX_WINDOW)) begin
                    if (!tuning) begin
                        tuning = 1'b1;
                        tune_t0 = m.now_ticks;
                    end
                    elapsed = m.now_ticks - tune_t0;
                    if (elapsed > tmo_r) begin
                        tuning = 1'b0;
                        r.action = ACT_RECAL;
                    end else begin
                        stp = (dev > 32'(QUICK_LIMIT)) ? 32'(quick_r) : 32'(slow_r);
                        r.step_size = 8'(stp);
                        r.dim_gap = (stp > 1) ? GAP_LONG : GAP_SHORT;
                        if (below) begin
                            up = 32'(m.pwm_width) + stp;
                            if (up < 32'(period_r) && stp != 0) begin
                                r.action = ACT_DIM;
                                r.new_width = 16'(up);
                            end
                        end else if (32'(m.pwm_width) > stp && stp != 0) begin
                            r.action = ACT_DIM;
                            r.new_width = 16'(32'(m.pwm_width) - stp);
                        end
                    end
                end else begin
                    tuning = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // input side
    always @(posedge i_clk) begin : drive
        t_out r;
        bit   took;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            took = i_in_valid && o_in_ready;
            if (took) begin
                r = regulate(i_in_data);
                reports_due.push_back(r);
                void'(meas_queue.pop_front());
                n_items++;
                if (r.action == ACT_DIM) n_dim++;
                if (r.action == ACT_RECAL) n_recal++;
                if (i_in_data.raw_reading == RAW_FAULT) n_fault++;
                if (i_in_data.dim_busy) n_busy++;
            end
            if (i_in_valid && !took) begin
                // hold until the transfer
            end else if (meas_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 36)) begin
                i_in_valid <= 1'b1;
                i_in_data  <= meas_queue[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output side stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(0, 99) >= 36);
        end
    end

    task automatic check_field(input string fld, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch in result %0d, %s: expected %0d, got %0d",
                         n_results, fld, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (reports_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: lux %0d action %0d width %0d",
                             o_out_data.current_lux, o_out_data.action,
                             o_out_data.new_width);
                end
            end else begin
                want = reports_due.pop_front();
                check_field("current_lux", want.current_lux, o_out_data.current_lux);
                check_field("action", want.action, o_out_data.action);
                check_field("new_width", want.new_width, o_out_data.new_width);
                check_field("step_size", want.step_size, o_out_data.step_size);
                check_field("dim_gap", want.dim_gap, o_out_data.dim_gap);
                n_results++;
            end
        end
    end

    function automatic t_in mk(input int unsigned raw, input int unsigned tgt,
                               input int unsigned w, input bit busy,
                               input logic [31:0] now);
        t_in m;
        m.raw_reading = 16'(raw);
        m.target_lux  = 16'(tgt);
        m.pwm_width   = 16'(w);
        m.dim_busy    = busy;
        m.now_ticks   = now;
        return m;
    endfunction

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [15:0] period, input logic [7:0] quick,
                            input logic [7:0] slow, input logic [31:0] tmo);
        write_reg(CFG_PWM_PERIOD, 32'(period));
        write_reg(CFG_QUICK_STEP, 32'(quick));
        write_reg(CFG_SLOW_STEP, 32'(slow));
        write_reg(CFG_TUNE_TIMEOUT, tmo);
        period_r = period;
        quick_r  = quick;
        slow_r   = slow;
        tmo_r    = tmo;
        n_settings++;
    endtask

    task automatic drain();
        while (meas_queue.size() != 0 || reports_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // runs of measurements with advancing ticks so tuning and timeouts get exercised
    task automatic add_burst(input int n);
        int unsigned tick;
        int unsigned span;
        int unsigned tgt;
        int unsigned w;
        int unsigned mag;
        int          l;
        t_in         m;
        tick = $urandom();
        span = ($urandom_range(0, 3) == 0) ? $urandom() : (tmo_r >> 2) + $urandom_range(1, 64);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 8) begin
                m.raw_reading = 16'($urandom());
                m.target_lux  = 16'($urandom());
                m.pwm_width   = 16'($urandom());
                m.dim_busy    = 1'($urandom());
                m.now_ticks   = $urandom();
            end else begin
                case ($urandom_range(0, 9))
                    0: tgt = 0;
                    1: tgt = $urandom_range(1, 65535);
                    default: tgt = $urandom_range(1, 3000);
                endcase
                case ($urandom_range(0, 5))
                    0: mag = $urandom_range(0, 20);
                    2: mag = $urandom_range(201, 4000);
                    3: begin
                        case ($urandom_range(0, 3))
                            0: mag = 20;
                            1: mag = 21;
                            2: mag = 200;
                            default: mag = 201;
                        endcase
                    end
                    default: mag = $urandom_range(21, 200);
                endcase
                l = $urandom_range(0, 1) ? int'(tgt) + int'(mag) : int'(tgt) - int'(mag);
                if (l < 0) l = 0;
                if (l > 54611) l = 54611;
                w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 32'(period_r) + 300);
                if (w > 65535) w = 65535;
                m = mk((l * 6 + 4) / 5, tgt, w, $urandom_range(0, 11) == 0, tick);
                if ($urandom_range(0, 19) == 0) m.raw_reading = RAW_FAULT;
            end
            meas_queue.push_back(m);
            tick += $urandom_range(0, span);
        end
    endtask

    task automatic random_phase(input int bursts);
        for (int b = 0; b < bursts; b++) add_burst($urandom_range(15, 28));
        drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: boundaries, fault, busy, timeout and tick wrap
        meas_queue.push_back(mk(0, 0, 0, 0, 0));
        meas_queue.push_back(mk(0, 0, 500, 0, 1));
        meas_queue.push_back(mk(16'hFFFF, 500, 500, 0, 2));
        meas_queue.push_back(mk(600, 100, 500, 1, 3));
        meas_queue.push_back(mk(65534, 65535, 65535, 0, 32'hFFFF_FFFF));
        meas_queue.push_back(mk(120, 120, 300, 0, 5));
        meas_queue.push_back(mk(120, 121, 300, 0, 10));
        meas_queue.push_back(mk(120, 300, 300, 0, 11));
        meas_queue.push_back(mk(120, 301, 300, 0, 12));
        meas_queue.push_back(mk(720, 100, 500, 0, 13));
        meas_queue.push_back(mk(720, 100, 34, 0, 14));
        meas_queue.push_back(mk(720, 100, 35, 0, 15));
        meas_queue.push_back(mk(120, 130, 992, 0, 16));
        meas_queue.push_back(mk(120, 130, 991, 0, 17));
        meas_queue.push_back(mk(120, 130, 100, 0, 30010));
        meas_queue.push_back(mk(120, 130, 100, 0, 30011));
        meas_queue.push_back(mk(120, 130, 100, 0, 32'hFFFF_FF00));
        meas_queue.push_back(mk(16'hFFFF, 130, 100, 0, 32'h0001_0000));
        meas_queue.push_back(mk(120, 130, 100, 1, 32'h0002_0000));
        meas_queue.push_back(mk(120, 130, 100, 0, 32'h0000_0010));
        meas_queue.push_back(mk(0, 65535, 0, 0, 32'h0000_7000));
        meas_queue.push_back(mk(65534, 0, 65535, 0, 32'h1234_5678));
        meas_queue.push_back(mk(65534, 1, 1, 0, 100));
        drain();

        // no stalls on either side
        calm = 1'b1;
        random_phase(4);
        calm = 1'b0;

        set_regs(16'hFFFF, 8'hFF, 8'd1, 32'hFFFF_FFFF);
        random_phase(5);
        set_regs(16'd1, 8'd0, 8'd0, 32'd0);
        random_phase(5);
        set_regs(PWM_PERIOD_RST, QUICK_STEP_RST, SLOW_STEP_RST, TUNE_TIMEOUT_RST);
        random_phase(5);
        for (int p = 0; p < 4; p++) begin
            set_regs($urandom_range(0, 1) ? 16'($urandom_range(50, 4000))
                                          : 16'($urandom_range(1, 65535)),
                     8'($urandom()), 8'($urandom()),
                     $urandom_range(0, 1) ? $urandom_range(0, 100000) : $urandom());
            random_phase(5);
        end

        repeat (10) @(posedge i_clk);
        $display("%0d measurements checked over %0d register settings", n_results, n_settings);
        $display("%0d dim requests, %0d recalibrations, %0d faults, %0d busy",
                 n_dim, n_recal, n_fault, n_busy);
        if (mismatches == 0 && reports_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, reports_due.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout after %0d transfers in, %0d results", n_items, n_results);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
